>>> rtl/fundamental_from_projection_pair_macros.svh
// Assertion helpers for the fundamental_from_projection_pair module.
// Each macro expects aclk and aresetn to be visible in the using module.
`ifndef FUNDAMENTAL_FROM_PROJECTION_PAIR_MACROS_SVH
`define FUNDAMENTAL_FROM_PROJECTION_PAIR_MACROS_SVH

// Same-cycle implication
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fpp_pkg.sv
package fpp_pkg;

    // Element and arithmetic widths
    localparam int ELEMENT_BITS       = 14;
    localparam int ELEMENT_FIELD_BITS = 14;
    localparam int MINOR_BITS         = 2 * ELEMENT_BITS + 1;
    localparam int PROD_BITS          = 2 * MINOR_BITS;
    localparam int DET_BITS           = 58;

    // Store layout: first matrix in 0..11, second in 12..23
    localparam int MAT_ELEMS   = 12;
    localparam int STORE_DEPTH = 2 * MAT_ELEMS;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    // Stream widths
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 64;

    // Terms of the Laplace expansion and steps within one term
    localparam int NUM_TERMS  = 6;
    localparam int TERM_BITS  = $clog2(NUM_TERMS);
    localparam int LAST_STEP  = 4;
    localparam int STEP_BITS  = $clog2(LAST_STEP + 1);

    // Row rotation tables
    localparam logic [1:0] NEXT_ROW_A [0:2] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] NEXT_ROW_B [0:2] = '{2'd2, 2'd0, 2'd1};

    // Column pairs of the top minor, of the complementary bottom minor, and sign
    localparam logic [1:0] TOP_COL_I [0:NUM_TERMS-1] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] TOP_COL_J [0:NUM_TERMS-1] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    localparam logic [1:0] BOT_COL_I [0:NUM_TERMS-1] = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
    localparam logic [1:0] BOT_COL_J [0:NUM_TERMS-1] = '{2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1};
    localparam logic       TERM_NEG  [0:NUM_TERMS-1] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MUL,
        ST_UPD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_S_SET,
        OP_S_SUB,
        OP_C_SET,
        OP_C_SUB,
        OP_D_SET,
        OP_D_ADD,
        OP_D_SUB
    } upd_op_t;

    typedef struct packed {
        logic    load_a;
        logic    load_b;
        logic    from_minors;
        logic    mul_en;
        logic    upd_en;
        upd_op_t upd_op;
    } det_ctrl_t;

endpackage

>>> rtl/fpp_det_unit.sv
module fpp_det_unit (
    input  logic                                      aclk,
    input  fpp_pkg::det_ctrl_t                        ctrl,
    input  logic signed [fpp_pkg::ELEMENT_BITS-1:0]   elem,
    output logic signed [fpp_pkg::DET_BITS-1:0]       det
);
    import fpp_pkg::*;

    logic signed [MINOR_BITS-1:0] op_a_reg;
    logic signed [MINOR_BITS-1:0] op_b_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  prod_next;
    logic signed [MINOR_BITS-1:0] minor_s_reg;
    logic signed [MINOR_BITS-1:0] minor_c_reg;
    logic signed [DET_BITS-1:0]   det_reg;
    logic signed [MINOR_BITS-1:0] elem_ext;
    logic signed [MINOR_BITS-1:0] prod_short;
    logic signed [DET_BITS-1:0]   prod_long;

    assign elem_ext   = MINOR_BITS'(elem);
    assign prod_next  = op_a_reg * op_b_reg;
    assign prod_short = prod_reg[MINOR_BITS-1:0];
    assign prod_long  = DET_BITS'(prod_reg);

    // Operand capture: store elements for minors, minors for the final product
    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            op_a_reg <= ctrl.from_minors ? minor_s_reg : elem_ext;
        end
        if (ctrl.load_b) begin
            op_b_reg <= ctrl.from_minors ? minor_c_reg : elem_ext;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Shared set / accumulate / subtract stage
    always_ff @(posedge aclk) begin
        if (ctrl.upd_en) begin
            case (ctrl.upd_op)
                OP_S_SET: minor_s_reg <= prod_short;
                OP_S_SUB: minor_s_reg <= minor_s_reg - prod_short;
                OP_C_SET: minor_c_reg <= prod_short;
                OP_C_SUB: minor_c_reg <= minor_c_reg - prod_short;
                OP_D_SET: det_reg     <= prod_long;
                OP_D_ADD: det_reg     <= det_reg + prod_long;
                OP_D_SUB: det_reg     <= det_reg - prod_long;
                default:  det_reg     <= det_reg;
            endcase
        end
    end

    assign det = det_reg;

endmodule

>>> rtl/fundamental_from_projection_pair.sv
// Fundamental matrix from two 3x4 camera projection matrices.
// Input stream (s_): one matrix element per transaction. s_tuser selects the
// matrix (0 first, 1 second), s_tdata carries row, column and a signed Q2.12
// element. s_tlast asks for the nine fundamental matrix entries after the
// element is stored. An element with row three is not stored.
// Output stream (m_): one entry per transaction in row-major order, with
// row, column and the exact 58-bit determinant (48 fractional bits);
// m_tlast marks the ninth entry.
// Sequencing: a load transaction is taken while the sequencer is idle. A
// compute transaction runs 6 terms x 5 multiply steps per entry, each step
// passing LOAD_A, LOAD_B, MUL and UPD through one shared 29x29 multiplier,
// then EMIT hands the entry to the output register. s_tready is low for the
// whole run. A stalled receiver holds the sequencer in its EMIT state;
// the last entry may wait in the output register while new loads are taken.
// Reset clears both matrices to zero and empties the output register.
module fundamental_from_projection_pair (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] row_index, [3:2] column_index, [17:4] element_value, [23:18] zero
    input  logic [fpp_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // [0] matrix_select
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] result_row, [3:2] result_column, [61:4] determinant_value,
    // [63:62] zero
    output logic [fpp_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic                                 m_tlast
);
    import fpp_pkg::*;
    `include "fundamental_from_projection_pair_macros.svh"

    localparam int OUT_PAD = OUT_DATA_BITS - (4 + DET_BITS);

    state_t                         state_reg, state_next;
    logic [STEP_BITS-1:0]           step_reg, step_next;
    logic [TERM_BITS-1:0]           term_reg, term_next;
    logic [1:0]                     res_r_reg, res_r_next;
    logic [1:0]                     res_c_reg, res_c_next;
    logic signed [ELEMENT_BITS-1:0] store_reg [STORE_DEPTH];

    logic                           out_valid_reg;
    logic [1:0]                     out_row_reg;
    logic [1:0]                     out_col_reg;
    logic signed [DET_BITS-1:0]     out_det_reg;
    logic                           out_last_reg;

    det_ctrl_t                      ctrl;
    logic signed [DET_BITS-1:0]     det;
    logic signed [ELEMENT_BITS-1:0] rd_elem;

    logic                           in_accept;
    logic                           out_free;
    logic                           res_last;
    logic [1:0]                     in_row;
    logic [1:0]                     in_col;
    logic [ADDR_BITS-1:0]           wr_addr;

    logic                           is_b;
    logic                           top_side;
    logic [1:0]                     col_i;
    logic [1:0]                     col_j;
    logic [1:0]                     rd_row;
    logic [1:0]                     rd_col;
    logic                           rd_sel;
    logic [ADDR_BITS-1:0]           rd_addr;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign res_last  = (res_r_reg == 2'd2) && (res_c_reg == 2'd2);
    assign in_row    = s_tdata[1:0];
    assign in_col    = s_tdata[3:2];
    assign wr_addr   = (s_tuser ? ADDR_BITS'(MAT_ELEMS) : '0) + ADDR_BITS'({in_row, in_col});

    // Element store, zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                store_reg[k] <= '0;
            end
        end else if (in_accept && (in_row != 2'd3)) begin
            store_reg[wr_addr] <= s_tdata[4 +: ELEMENT_BITS];
        end
    end

    // Operand address: top rows from the second matrix, bottom rows from the first
    always_comb begin
        is_b     = (state_reg == ST_LOAD_B);
        top_side = (step_reg < STEP_BITS'(2));
        col_i    = top_side ? TOP_COL_I[term_reg] : BOT_COL_I[term_reg];
        col_j    = top_side ? TOP_COL_J[term_reg] : BOT_COL_J[term_reg];
        if (top_side) begin
            rd_row = is_b ? NEXT_ROW_B[res_c_reg] : NEXT_ROW_A[res_c_reg];
        end else begin
            rd_row = is_b ? NEXT_ROW_B[res_r_reg] : NEXT_ROW_A[res_r_reg];
        end
        rd_col  = (is_b ^ step_reg[0]) ? col_j : col_i;
        rd_sel  = top_side;
        rd_addr = (rd_sel ? ADDR_BITS'(MAT_ELEMS) : '0) + ADDR_BITS'({rd_row, rd_col});
    end

    assign rd_elem = store_reg[rd_addr];

    // Next state and counters
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        term_next  = term_reg;
        res_r_next = res_r_reg;
        res_c_next = res_c_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tlast) begin
                    state_next = ST_LOAD_A;
                    step_next  = '0;
                    term_next  = '0;
                    res_r_next = '0;
                    res_c_next = '0;
                end
            end
            ST_LOAD_A: state_next = ST_LOAD_B;
            ST_LOAD_B: state_next = ST_MUL;
            ST_MUL:    state_next = ST_UPD;
            ST_UPD: begin
                if (step_reg != STEP_BITS'(LAST_STEP)) begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_LOAD_A;
                end else begin
                    step_next = '0;
                    if (term_reg != TERM_BITS'(NUM_TERMS - 1)) begin
                        term_next  = term_reg + 1'b1;
                        state_next = ST_LOAD_A;
                    end else begin
                        term_next  = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (res_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LOAD_A;
                        if (res_c_reg == 2'd2) begin
                            res_c_next = '0;
                            res_r_next = res_r_reg + 1'b1;
                        end else begin
                            res_c_next = res_c_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        ctrl.load_a      = (state_reg == ST_LOAD_A);
        ctrl.load_b      = (state_reg == ST_LOAD_B);
        ctrl.from_minors = (step_reg == STEP_BITS'(LAST_STEP));
        ctrl.mul_en      = (state_reg == ST_MUL);
        ctrl.upd_en      = (state_reg == ST_UPD);
        case (step_reg)
            STEP_BITS'(0): ctrl.upd_op = OP_S_SET;
            STEP_BITS'(1): ctrl.upd_op = OP_S_SUB;
            STEP_BITS'(2): ctrl.upd_op = OP_C_SET;
            STEP_BITS'(3): ctrl.upd_op = OP_C_SUB;
            default: begin
                if (term_reg == '0) begin
                    ctrl.upd_op = OP_D_SET;
                end else begin
                    ctrl.upd_op = TERM_NEG[term_reg] ? OP_D_SUB : OP_D_ADD;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            term_reg      <= '0;
            res_r_reg     <= '0;
            res_c_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            term_reg  <= term_next;
            res_r_reg <= res_r_next;
            res_c_reg <= res_c_next;
            if ((state_reg == ST_EMIT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_free) begin
            out_row_reg  <= res_r_reg;
            out_col_reg  <= res_c_reg;
            out_det_reg  <= det;
            out_last_reg <= res_last;
        end
    end

    fpp_det_unit u_det (
        .aclk (aclk),
        .ctrl (ctrl),
        .elem (rd_elem),
        .det  (det)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_PAD'(0), out_det_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    `FPP_ASSERT_NOW(a_last_is_corner, out_valid_reg && out_last_reg,
        (out_row_reg == 2'd2) && (out_col_reg == 2'd2), "last entry is not (2,2)")
    `FPP_ASSERT_NOW(a_counters_in_range, 1'b1,
        (step_reg <= STEP_BITS'(LAST_STEP)) && (term_reg <= TERM_BITS'(NUM_TERMS - 1)),
        "step or term counter out of range")
    `FPP_ASSERT_NEXT(a_run_starts_clean, in_accept && s_tlast,
        (state_reg == ST_LOAD_A) && (step_reg == '0) && (term_reg == '0)
        && (res_r_reg == '0) && (res_c_reg == '0), "compute run did not start at entry (0,0)")
    `FPP_ASSERT_NEXT(a_run_ends_idle, (state_reg == ST_EMIT) && out_free && res_last,
        (state_reg == ST_IDLE) && out_valid_reg && out_last_reg,
        "ninth entry did not end the run")

endmodule
